// File: hw/rtl/utdb_pkg.sv
// Shared types and constants for the USB transfer descriptor builder.
// Used by utdb_front, utdb_queue, utdb_back and the top level.
package utdb_pkg;

    localparam int TD_SLOTS       = 16;
    localparam int DATA_BYTES_MAX = 1024;
    localparam int RESULT_CAP     = 16;
    localparam int SLOT_LIM       = (TD_SLOTS > RESULT_CAP) ? RESULT_CAP :
                                    ((TD_SLOTS < 3) ? 3 : TD_SLOTS);
    localparam int CNT_W          = $clog2(SLOT_LIM + 1);

    localparam int DEV_W     = 7;
    localparam int EP_W      = 4;
    localparam int MP_W      = 10;
    localparam int LEN_W     = 12;
    localparam int LCODE_W   = 11;
    localparam int TOG_AW    = DEV_W + EP_W;
    localparam int TOG_DEPTH = 1 << TOG_AW;

    localparam int QUEUE_DEPTH = 2;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 48;

    localparam logic [1:0] CMD_CTRL = 2'd0;
    localparam logic [1:0] CMD_DATA = 2'd1;
    localparam logic [1:0] CMD_DONE = 2'd2;

    localparam logic [1:0] PID_SETUP = 2'd0;
    localparam logic [1:0] PID_IN    = 2'd1;
    localparam logic [1:0] PID_OUT   = 2'd2;

    localparam logic [1:0] BUF_NONE  = 2'd0;
    localparam logic [1:0] BUF_SETUP = 2'd1;
    localparam logic [1:0] BUF_DATA  = 2'd2;

    localparam logic [1:0] STS_OK   = 2'd0;
    localparam logic [1:0] STS_NAK  = 2'd1;
    localparam logic [1:0] STS_FAIL = 2'd2;

    localparam logic [1:0] OUTCOME_OK  = 2'd0;
    localparam logic [1:0] OUTCOME_NAK = 2'd1;

    localparam logic [MP_W-1:0]    MP_DEFAULT  = 10'd8;
    localparam logic [LCODE_W-1:0] SETUP_LCODE = 11'd7;
    localparam logic [LCODE_W-1:0] ZERO_LCODE  = 11'h7FF;

    typedef enum logic [1:0] {
        OP_CTRL,
        OP_DATA,
        OP_DONE
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [DEV_W-1:0] dev;
        logic [EP_W-1:0]  ep;
        logic             dir_in;
        logic             slow;
        logic [MP_W-1:0]  max_pkt;
        logic [LEN_W-1:0] len;
        logic [1:0]       outcome;
    } t_req;

    typedef struct packed {
        logic               kind;
        logic               last;
        logic [1:0]         pid;
        logic [DEV_W-1:0]   dev;
        logic [EP_W-1:0]    ep;
        logic               tog;
        logic               slow;
        logic [LCODE_W-1:0] lcode;
        logic [1:0]         bkind;
        logic [LEN_W-1:0]   boff;
        logic [1:0]         cstatus;
    } t_word;

endpackage

// File: hw/rtl/utdb_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module utdb_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/utdb_front.sv
// Front end: accepts input words, decodes the command and normalizes fields.
// Depends on utdb_pkg.
module utdb_front (
    input  logic                           i_tvalid,
    output logic                           o_tready,
    input  logic [utdb_pkg::S_TDATA_W-1:0] i_tdata,
    input  logic [utdb_pkg::S_TUSER_W-1:0] i_tuser,
    input  logic                           i_q_full,
    input  logic                           i_clearing,
    output logic                           o_push,
    output utdb_pkg::t_req                 o_req
);
    import utdb_pkg::*;

    logic             known;
    logic [MP_W-1:0]  mp;
    logic [LEN_W-1:0] len;

    assign mp  = i_tdata[22:13];
    assign len = i_tdata[34:23];

    always_comb begin
        known    = 1'b1;
        o_req.op = OP_CTRL;
        case (i_tuser)
            CMD_CTRL: o_req.op = OP_CTRL;
            CMD_DATA: o_req.op = OP_DATA;
            CMD_DONE: o_req.op = OP_DONE;
            default:  known = 1'b0;
        endcase
        o_req.dev     = i_tdata[6:0];
        o_req.ep      = i_tdata[10:7];
        o_req.dir_in  = i_tdata[11];
        o_req.slow    = i_tdata[12];
        o_req.max_pkt = (mp == '0) ? MP_DEFAULT : mp;
        o_req.len     = (len > LEN_W'(DATA_BYTES_MAX)) ? LEN_W'(DATA_BYTES_MAX) : len;
        o_req.outcome = i_tdata[36:35];
    end

    assign o_tready = !i_q_full && !i_clearing;
    assign o_push   = i_tvalid && o_tready && known;

endmodule

// File: hw/rtl/utdb_queue.sv
// Short request queue between the front end and the descriptor sequencer.
// Depends on utdb_pkg.
module utdb_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  utdb_pkg::t_req i_req,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output utdb_pkg::t_req o_req
);
    import utdb_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    t_req              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_QW-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == CNT_QW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_req   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/utdb_back.sv
// Back end: sequences descriptor chains and completion status words,
// owns the toggle table RAM and the pending-request state. Depends on utdb_pkg, utdb_ram.
module utdb_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  utdb_pkg::t_req i_req,
    output logic           o_pop,
    output logic           o_clearing,
    output logic           o_m_valid,
    input  logic           i_m_ready,
    output utdb_pkg::t_word o_word
);
    import utdb_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TOGRD,
        ST_RUN
    } t_state;

    typedef enum logic [2:0] {
        PH_SETUP,
        PH_CDATA,
        PH_CSTAT,
        PH_XFER,
        PH_CPL
    } t_phase;

    typedef enum logic [1:0] {
        PEND_NONE,
        PEND_OUT,
        PEND_IN,
        PEND_CTRL
    } t_pend;

    t_state            r_state,    n_state;
    t_phase            r_phase,    n_phase;
    t_req              r_req,      n_req;
    logic [TOG_AW-1:0] r_clr_addr, n_clr_addr;
    logic [LEN_W-1:0]  r_rem,      n_rem;
    logic [LEN_W-1:0]  r_off,      n_off;
    logic [CNT_W-1:0]  r_cnt,      n_cnt;
    logic              r_tog,      n_tog;
    t_pend             r_pend,     n_pend;
    logic [TOG_AW-1:0] r_pend_slot, n_pend_slot;
    logic              r_pend_tog, n_pend_tog;
    logic              r_out_valid, n_out_valid;
    t_word             r_out,      n_out;

    logic              ram_en;
    logic              ram_we;
    logic [TOG_AW-1:0] ram_addr;
    logic              ram_wdata;
    logic              ram_rdata;

    logic               advance;
    logic [LEN_W-1:0]   mp;
    logic [LEN_W-1:0]   chunk;
    logic [LEN_W-1:0]   rem_nx;
    logic [LEN_W-1:0]   off_nx;
    logic [CNT_W-1:0]   cnt_nx;
    logic [LEN_W-1:0]   chunk_m1;
    logic [LCODE_W-1:0] lcode;
    logic               more;
    t_word              w;

    utdb_ram #(
        .WIDTH (1),
        .DEPTH (TOG_DEPTH)
    ) u_tog_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign advance  = !r_out_valid || i_m_ready;
    assign mp       = LEN_W'(r_req.max_pkt);
    assign chunk    = (r_rem > mp) ? mp : r_rem;
    assign rem_nx   = r_rem - chunk;
    assign off_nx   = r_off + chunk;
    assign cnt_nx   = r_cnt + 1'b1;
    assign chunk_m1 = chunk - 1'b1;
    assign lcode    = chunk_m1[LCODE_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_req       = r_req;
        n_clr_addr  = r_clr_addr;
        n_rem       = r_rem;
        n_off       = r_off;
        n_cnt       = r_cnt;
        n_tog       = r_tog;
        n_pend      = r_pend;
        n_pend_slot = r_pend_slot;
        n_pend_tog  = r_pend_tog;
        n_out_valid = r_out_valid && !i_m_ready;
        n_out       = r_out;
        ram_en      = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = r_clr_addr;
        ram_wdata   = 1'b0;
        o_pop       = 1'b0;
        more        = 1'b0;
        w           = '0;
        w.dev       = r_req.dev;
        w.slow      = r_req.slow;

        case (r_state)
            ST_CLEAR: begin
                ram_en     = 1'b1;
                ram_we     = 1'b1;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == TOG_AW'(TOG_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_pop = 1'b1;
                    n_req = i_req;
                    n_rem = i_req.len;
                    n_off = '0;
                    n_cnt = '0;
                    n_tog = 1'b1;
                    case (i_req.op)
                        OP_DATA: begin
                            ram_en   = 1'b1;
                            ram_addr = {i_req.dev, i_req.ep};
                            n_state  = ST_TOGRD;
                        end
                        OP_CTRL: begin
                            n_phase = PH_SETUP;
                            n_state = ST_RUN;
                        end
                        default: begin
                            n_phase = PH_CPL;
                            n_state = ST_RUN;
                        end
                    endcase
                end
            end
            ST_TOGRD: begin
                n_tog   = ram_rdata;
                n_phase = PH_XFER;
                n_state = ST_RUN;
            end
            ST_RUN: begin
                case (r_phase)
                    PH_SETUP: begin
                        w.pid   = PID_SETUP;
                        w.lcode = SETUP_LCODE;
                        w.bkind = BUF_SETUP;
                    end
                    PH_CDATA: begin
                        w.pid   = r_req.dir_in ? PID_IN : PID_OUT;
                        w.tog   = r_tog;
                        w.lcode = lcode;
                        w.bkind = BUF_DATA;
                        w.boff  = r_off;
                        more    = (rem_nx != '0) && (cnt_nx < CNT_W'(SLOT_LIM - 1));
                    end
                    PH_CSTAT: begin
                        w.pid   = r_req.dir_in ? PID_OUT : PID_IN;
                        w.tog   = 1'b1;
                        w.lcode = ZERO_LCODE;
                        w.last  = 1'b1;
                    end
                    PH_XFER: begin
                        w.pid = r_req.dir_in ? PID_IN : PID_OUT;
                        w.ep  = r_req.ep;
                        w.tog = r_tog;
                        if (chunk != '0) begin
                            w.lcode = lcode;
                            w.bkind = BUF_DATA;
                            w.boff  = r_off;
                        end else begin
                            w.lcode = ZERO_LCODE;
                        end
                        more   = (rem_nx != '0) && (cnt_nx < CNT_W'(SLOT_LIM));
                        w.last = !more;
                    end
                    default: begin
                        w      = '0;
                        w.kind = 1'b1;
                        if (r_pend == PEND_NONE) begin
                            w.cstatus = STS_FAIL;
                        end else if (r_req.outcome == OUTCOME_OK) begin
                            w.cstatus = STS_OK;
                        end else if (r_req.outcome == OUTCOME_NAK && r_pend == PEND_IN) begin
                            w.cstatus = STS_NAK;
                        end else begin
                            w.cstatus = STS_FAIL;
                        end
                    end
                endcase

                if (advance) begin
                    n_out_valid = 1'b1;
                    n_out       = w;
                    n_cnt       = cnt_nx;
                    case (r_phase)
                        PH_SETUP: begin
                            n_phase = (r_rem != '0) ? PH_CDATA : PH_CSTAT;
                        end
                        PH_CDATA: begin
                            n_tog = !r_tog;
                            n_rem = rem_nx;
                            n_off = off_nx;
                            if (!more) begin
                                n_phase = PH_CSTAT;
                            end
                        end
                        PH_CSTAT: begin
                            n_pend      = PEND_CTRL;
                            n_pend_slot = '0;
                            n_pend_tog  = 1'b0;
                            n_state     = ST_IDLE;
                        end
                        PH_XFER: begin
                            n_tog = !r_tog;
                            n_rem = rem_nx;
                            n_off = off_nx;
                            if (!more) begin
                                n_pend      = r_req.dir_in ? PEND_IN : PEND_OUT;
                                n_pend_slot = {r_req.dev, r_req.ep};
                                n_pend_tog  = !r_tog;
                                n_state     = ST_IDLE;
                            end
                        end
                        default: begin
                            if (r_pend != PEND_NONE) begin
                                if (r_req.outcome == OUTCOME_OK &&
                                    (r_pend == PEND_IN || r_pend == PEND_OUT)) begin
                                    ram_en    = 1'b1;
                                    ram_we    = 1'b1;
                                    ram_addr  = r_pend_slot;
                                    ram_wdata = r_pend_tog;
                                end
                                n_pend      = PEND_NONE;
                                n_pend_slot = '0;
                                n_pend_tog  = 1'b0;
                            end
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_rem <= n_rem;
        r_off <= n_off;
        r_cnt <= n_cnt;
        r_tog <= n_tog;
        r_out <= n_out;
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_phase     <= PH_SETUP;
            r_clr_addr  <= '0;
            r_pend      <= PEND_NONE;
            r_pend_slot <= '0;
            r_pend_tog  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_clr_addr  <= n_clr_addr;
            r_pend      <= n_pend;
            r_pend_slot <= n_pend_slot;
            r_pend_tog  <= n_pend_tog;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_clearing = (r_state == ST_CLEAR);
    assign o_m_valid  = r_out_valid;
    assign o_word     = r_out;

endmodule

// File: hw/rtl/usb_transfer_descriptor_builder.sv
// USB transfer descriptor builder top level: front end, request queue, sequencer.
// Requests pass from the queue to the sequencer, which first reads the toggle table
// for data requests; words leave through the output register. Throughput: one word
// per cycle unless m_axis_tready stalls it, up to 16 per request, after a dispatch
// state; the sequencer handles one request at a time. Reset: synchronous, active low;
// then all 2048 toggle table entries are cleared and no input word is accepted.
module usb_transfer_descriptor_builder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // device address, endpoint, direction in, slow device, packet size limit,
    // length, outcome, zero pad
    input  logic [utdb_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // cmd
    input  logic [utdb_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // pid, device, endpoint, toggle, slow flag, length code,
    // buffer kind, buffer offset, completion status, zero pad
    output logic [utdb_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // kind
    output logic                           m_axis_tuser,
    output logic                           m_axis_tlast
);
    import utdb_pkg::*;

    logic  push;
    t_req  front_req;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;
    t_req  q_req;
    logic  clearing;
    t_word word;

    utdb_front u_front (
        .i_tvalid   (s_axis_tvalid),
        .o_tready   (s_axis_tready),
        .i_tdata    (s_axis_tdata),
        .i_tuser    (s_axis_tuser),
        .i_q_full   (q_full),
        .i_clearing (clearing),
        .o_push     (push),
        .o_req      (front_req)
    );

    utdb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (front_req),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_req   (q_req)
    );

    utdb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_req      (q_req),
        .o_pop      (q_pop),
        .o_clearing (clearing),
        .o_m_valid  (m_axis_tvalid),
        .i_m_ready  (m_axis_tready),
        .o_word     (word)
    );

    assign m_axis_tdata = {6'b0, word.cstatus, word.boff, word.bkind, word.lcode,
                           word.slow, word.tog, word.ep, word.dev, word.pid};
    assign m_axis_tuser = word.kind;
    assign m_axis_tlast = word.last;

endmodule
